>>> sv/ascii_number_literal_parser_top_macros.svh
// Assertion macros for the ASCII number literal parser checker.
// Expects a clock named clk and a reset named rst in the using scope.
`ifndef ASCII_NUMBER_LITERAL_PARSER_TOP_MACROS_SVH
`define ASCII_NUMBER_LITERAL_PARSER_TOP_MACROS_SVH

// Check a property outside reset
`define ANLP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("anlp assertion failed");

// Check a property at every edge, reset included
`define ANLP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("anlp assertion failed");

`endif

>>> sv/anlp_pkg.sv
// Shared constants for the ASCII number literal parser.
// No dependencies; used by the interfaces, the top level and the checker.
`default_nettype none

package anlp_pkg;

  // Value field width on the result word
  localparam int unsigned OUT_BITS = 31;
  // Default accumulator width
  localparam int unsigned VALUE_BITS_DEF = 31;
  // Byte width of one input word
  localparam int unsigned CH_BITS = 8;

  // Prefix positions: bytes seen, saturating at the first hex digit slot
  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_DIGITS = 2'd2;

  // Character codes
  localparam logic [CH_BITS-1:0] CH_NUL  = 8'd0;
  localparam logic [CH_BITS-1:0] CH_ZERO = 8'd48;
  localparam logic [CH_BITS-1:0] CH_ONE  = 8'd49;
  localparam logic [CH_BITS-1:0] CH_NINE = 8'd57;
  localparam logic [CH_BITS-1:0] CH_UP_A = 8'd65;
  localparam logic [CH_BITS-1:0] CH_UP_F = 8'd70;
  localparam logic [CH_BITS-1:0] CH_LO_A = 8'd97;
  localparam logic [CH_BITS-1:0] CH_LO_F = 8'd102;
  localparam logic [CH_BITS-1:0] CH_X    = 8'd120;

endpackage

`default_nettype wire

>>> sv/anlp_in_if.sv
// Byte channel into the parser: valid/ready handshake plus one character.
// Depends on anlp_pkg.
`default_nettype none

interface anlp_in_if;
  import anlp_pkg::*;

  logic               valid;
  logic               ready;
  logic [CH_BITS-1:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

`default_nettype wire

>>> sv/anlp_out_if.sv
// Result channel out of the parser: valid/ready handshake plus the three
// per-base verdicts. Depends on anlp_pkg.
`default_nettype none

interface anlp_out_if;
  import anlp_pkg::*;

  logic                valid;
  logic                ready;
  logic                dec_valid;
  logic [OUT_BITS-1:0] dec_value;
  logic                dec_overflow;
  logic                bin_valid;
  logic [OUT_BITS-1:0] bin_value;
  logic                bin_overflow;
  logic                hex_valid;
  logic [OUT_BITS-1:0] hex_value;
  logic                hex_overflow;

  modport source (
    output valid, input ready,
    output dec_valid, output dec_value, output dec_overflow,
    output bin_valid, output bin_value, output bin_overflow,
    output hex_valid, output hex_value, output hex_overflow
  );
  modport sink (
    input valid, output ready,
    input dec_valid, input dec_value, input dec_overflow,
    input bin_valid, input bin_value, input bin_overflow,
    input hex_valid, input hex_value, input hex_overflow
  );
endinterface

`default_nettype wire

>>> sv/ascii_number_literal_parser_top.sv
// Each byte is held in the input register; a zero byte's result word is then
// registered in the output register.
// Throughput: one byte per cycle; the accumulators take one shift-add each.
// A terminator stalls only while the previous result word is still held.
// Reset (synchronous, rst high) empties both registers and returns the
// accumulators, validity flags and prefix position to their start values.
`default_nettype none

module ascii_number_literal_parser_top #(
  parameter int unsigned VALUE_BITS = anlp_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  anlp_in_if.sink     chars,
  anlp_out_if.source  results
);
  import anlp_pkg::*;

  localparam int unsigned WX = VALUE_BITS + 4;

  typedef struct packed {
    logic                dec_valid;
    logic [OUT_BITS-1:0] dec_value;
    logic                dec_overflow;
    logic                bin_valid;
    logic [OUT_BITS-1:0] bin_value;
    logic                bin_overflow;
    logic                hex_valid;
    logic [OUT_BITS-1:0] hex_value;
    logic                hex_overflow;
  } result_t;

  // Saturating step: take the widened product-sum unless it spills over or overflow is already set
  function automatic logic [VALUE_BITS:0] sat_step(
    input logic          ovf,
    input logic [WX-1:0] prod
  );
    if (ovf || (|prod[WX-1:VALUE_BITS])) begin
      return {1'b1, {VALUE_BITS{1'b1}}};
    end
    return {1'b0, prod[VALUE_BITS-1:0]};
  endfunction

  // Input register
  logic               s1_valid;
  logic [CH_BITS-1:0] s1_ch;

  // Parse state
  logic [1:0]            position;
  logic                  dec_ok, bin_ok, hex_ok;
  logic [VALUE_BITS-1:0] dec_acc, bin_acc, hex_acc;
  logic                  dec_ovf, bin_ovf, hex_ovf;

  logic [1:0]            position_next;
  logic                  dec_ok_next, bin_ok_next, hex_ok_next;
  logic [VALUE_BITS-1:0] dec_acc_next, bin_acc_next, hex_acc_next;
  logic                  dec_ovf_next, bin_ovf_next, hex_ovf_next;

  // Output register
  logic    out_valid;
  result_t res;
  result_t res_next;

  logic s1_term;
  logic advance;

  assign s1_term = (s1_ch == CH_NUL);
  assign advance = s1_valid && (!s1_term || !out_valid || results.ready);
  assign chars.ready = !s1_valid || advance;

  // Capture the next byte whenever the input register frees up
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (chars.ready) begin
      s1_valid <= chars.valid;
    end
    if (chars.ready && chars.valid) begin
      s1_ch <= chars.ch;
    end
  end

  // Per-byte classification and accumulator update
  always_comb begin
    logic            is_dig, is_bin, is_up, is_lo;
    logic [3:0]      hex_d;
    logic [WX-1:0]   acc_w;
    logic [WX-1:0]   dec_prod, bin_prod, hex_prod;
    logic [VALUE_BITS:0] step;
    logic            hv;

    step   = '0;
    is_dig = (s1_ch >= CH_ZERO) && (s1_ch <= CH_NINE);
    is_bin = (s1_ch == CH_ZERO) || (s1_ch == CH_ONE);
    is_up  = (s1_ch >= CH_UP_A) && (s1_ch <= CH_UP_F);
    is_lo  = (s1_ch >= CH_LO_A) && (s1_ch <= CH_LO_F);
    // Letters A-F and a-f carry their value minus 9 in the low nibble
    hex_d  = is_dig ? s1_ch[3:0] : s1_ch[3:0] + 4'd9;

    position_next = position;
    dec_ok_next   = dec_ok;
    bin_ok_next   = bin_ok;
    hex_ok_next   = hex_ok;
    dec_acc_next  = dec_acc;
    bin_acc_next  = bin_acc;
    hex_acc_next  = hex_acc;
    dec_ovf_next  = dec_ovf;
    bin_ovf_next  = bin_ovf;
    hex_ovf_next  = hex_ovf;

    // Decimal: acc * 10 + digit as two shifts and an add
    acc_w    = WX'(dec_acc);
    dec_prod = (acc_w << 3) + (acc_w << 1) + WX'(s1_ch[3:0]);
    // Binary: acc * 2 + digit
    acc_w    = WX'(bin_acc);
    bin_prod = (acc_w << 1) + WX'(s1_ch[0]);
    // Hex: acc * 16 + digit
    acc_w    = WX'(hex_acc);
    hex_prod = (acc_w << 4) + WX'(hex_d);

    if (dec_ok) begin
      if (is_dig) begin
        step         = sat_step(dec_ovf, dec_prod);
        dec_ovf_next = step[VALUE_BITS];
        dec_acc_next = step[VALUE_BITS-1:0];
      end else begin
        dec_ok_next = 1'b0;
      end
    end

    if (bin_ok) begin
      if (is_bin) begin
        step         = sat_step(bin_ovf, bin_prod);
        bin_ovf_next = step[VALUE_BITS];
        bin_acc_next = step[VALUE_BITS-1:0];
      end else begin
        bin_ok_next = 1'b0;
      end
    end

    // Hex: check the 0x prefix, then take digits
    if (hex_ok) begin
      if (position == POS_FIRST) begin
        hex_ok_next = (s1_ch == CH_ZERO);
      end else if (position == POS_SECOND) begin
        hex_ok_next = (s1_ch == CH_X);
      end else if (is_dig || is_up || is_lo) begin
        step         = sat_step(hex_ovf, hex_prod);
        hex_ovf_next = step[VALUE_BITS];
        hex_acc_next = step[VALUE_BITS-1:0];
      end else begin
        hex_ok_next = 1'b0;
      end
    end

    if (position != POS_DIGITS) begin
      position_next = position + 2'd1;
    end

    // Result word built from the state before the terminator
    hv = hex_ok && (position == POS_DIGITS);
    res_next.dec_valid    = dec_ok;
    res_next.dec_value    = dec_ok ? OUT_BITS'(dec_acc) : '0;
    res_next.dec_overflow = dec_ok && dec_ovf;
    res_next.bin_valid    = bin_ok;
    res_next.bin_value    = bin_ok ? OUT_BITS'(bin_acc) : '0;
    res_next.bin_overflow = bin_ok && bin_ovf;
    res_next.hex_valid    = hv;
    res_next.hex_value    = hv ? OUT_BITS'(hex_acc) : '0;
    res_next.hex_overflow = hv && hex_ovf;
  end

  // Advance parse state; clear it on the terminator
  always_ff @(posedge clk) begin
    if (rst || (advance && s1_term)) begin
      position <= POS_FIRST;
      dec_ok   <= 1'b1;
      bin_ok   <= 1'b1;
      hex_ok   <= 1'b1;
      dec_acc  <= '0;
      bin_acc  <= '0;
      hex_acc  <= '0;
      dec_ovf  <= 1'b0;
      bin_ovf  <= 1'b0;
      hex_ovf  <= 1'b0;
    end else if (advance) begin
      position <= position_next;
      dec_ok   <= dec_ok_next;
      bin_ok   <= bin_ok_next;
      hex_ok   <= hex_ok_next;
      dec_acc  <= dec_acc_next;
      bin_acc  <= bin_acc_next;
      hex_acc  <= hex_acc_next;
      dec_ovf  <= dec_ovf_next;
      bin_ovf  <= bin_ovf_next;
      hex_ovf  <= hex_ovf_next;
    end
  end

  // Hold the result word until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1_term) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
    if (advance && s1_term) begin
      res <= res_next;
    end
  end

  assign results.valid        = out_valid;
  assign results.dec_valid    = res.dec_valid;
  assign results.dec_value    = res.dec_value;
  assign results.dec_overflow = res.dec_overflow;
  assign results.bin_valid    = res.bin_valid;
  assign results.bin_value    = res.bin_value;
  assign results.bin_overflow = res.bin_overflow;
  assign results.hex_valid    = res.hex_valid;
  assign results.hex_value    = res.hex_value;
  assign results.hex_overflow = res.hex_overflow;

endmodule

`default_nettype wire

>>> sv/anlp_checker.sv
// Port-level checks for the ASCII number literal parser, bound to its top.
// Depends on anlp_pkg and ascii_number_literal_parser_top_macros.svh.
`default_nettype none

`include "ascii_number_literal_parser_top_macros.svh"

module anlp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          dec_valid,
  input logic [anlp_pkg::OUT_BITS-1:0] dec_value,
  input logic                          dec_overflow,
  input logic                          bin_valid,
  input logic [anlp_pkg::OUT_BITS-1:0] bin_value,
  input logic                          bin_overflow,
  input logic                          hex_valid,
  input logic [anlp_pkg::OUT_BITS-1:0] hex_value,
  input logic                          hex_overflow
);
  import anlp_pkg::*;

  // Leave reset with the output register empty
  `ANLP_ASSERT_ALWAYS(a_no_result_after_reset, $past(rst) |-> !out_valid)

  // A stalled result word holds its payload
  `ANLP_ASSERT(a_stall_holds, (!$past(rst) && $past(out_valid && !out_ready)) |-> (out_valid && $stable(dec_value) && $stable(bin_value) && $stable(hex_value)))

  // A rejected base reports zero value and no overflow
  `ANLP_ASSERT(a_invalid_zero, out_valid |-> ((dec_valid || (dec_value == '0 && !dec_overflow)) && (bin_valid || (bin_value == '0 && !bin_overflow)) && (hex_valid || (hex_value == '0 && !hex_overflow))))

  // A hex literal carries an x in its prefix, so it is neither decimal nor binary
  `ANLP_ASSERT(a_hex_excludes_dec, (out_valid && hex_valid) |-> (!dec_valid && !bin_valid))

endmodule

bind ascii_number_literal_parser_top anlp_checker u_anlp_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .dec_valid    (results.dec_valid),
  .dec_value    (results.dec_value),
  .dec_overflow (results.dec_overflow),
  .bin_valid    (results.bin_valid),
  .bin_value    (results.bin_value),
  .bin_overflow (results.bin_overflow),
  .hex_valid    (results.hex_valid),
  .hex_value    (results.hex_value),
  .hex_overflow (results.hex_overflow)
);

`default_nettype wire

>>> tb/testbench.sv
// Self-checking bench for the ASCII number literal parser top level.
// Depends on anlp_pkg, anlp_in_if, anlp_out_if and ascii_number_literal_parser_top.
// Drives byte strings with random gaps and stalls and checks every result word.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import anlp_pkg::*;

  localparam logic [63:0] VALUE_MAX = (64'd1 << VALUE_BITS_DEF) - 64'd1;
  localparam logic [CH_BITS-1:0] CH_UP_X = 8'd88;
  localparam int PHASE_BYTES = 300;
  localparam int TAIL_CYCLES = 20;

  typedef struct packed {
    logic                dec_valid;
    logic [OUT_BITS-1:0] dec_value;
    logic                dec_overflow;
    logic                bin_valid;
    logic [OUT_BITS-1:0] bin_value;
    logic                bin_overflow;
    logic                hex_valid;
    logic [OUT_BITS-1:0] hex_value;
    logic                hex_overflow;
  } verdict_t;

  typedef struct {
    logic [CH_BITS-1:0] ch;
    bit                 typed;
    verdict_t           want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  anlp_in_if  chars();
  anlp_out_if results();

  ascii_number_literal_parser_top dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars),
    .results (results)
  );

  // Own copy of the literal scan state
  logic [1:0]  seen;
  logic        dec_ok, bin_ok, hex_ok;
  logic [63:0] dec_acc, bin_acc, hex_acc;
  logic        dec_ovf, bin_ovf, hex_ovf;

  verdict_t  pending_verdicts[$];
  stim_row_t directed_rows[$];
  int        errors = 0;
  int        sent_bytes = 0;
  int        send_idle_pct = 0;
  int        stall_pct = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Start a new literal
  function automatic void clear_literal();
    seen = POS_FIRST;
    dec_ok = 1'b1;
    bin_ok = 1'b1;
    hex_ok = 1'b1;
    dec_acc = '0;
    bin_acc = '0;
    hex_acc = '0;
    dec_ovf = 1'b0;
    bin_ovf = 1'b0;
    hex_ovf = 1'b0;
  endfunction

  // Multiply-add one digit, pinning at the maximum once it would exceed it
  function automatic void sat_mac(inout logic [63:0] acc, inout logic ovf,
                                  input logic [63:0] radix, input logic [63:0] digit);
    if (ovf || acc > (VALUE_MAX - digit) / radix) begin
      acc = VALUE_MAX;
      ovf = 1'b1;
    end else begin
      acc = acc * radix + digit;
    end
  endfunction

  // Advance the scan by one byte; return 1 with the verdict on a terminator
  function automatic bit parse_byte(input logic [CH_BITS-1:0] c, output verdict_t v);
    logic hv;
    int   nib;
    v = '0;
    if (c == CH_NUL) begin
      hv = hex_ok && (seen == POS_DIGITS);
      v.dec_valid    = dec_ok;
      v.dec_value    = dec_ok ? dec_acc[OUT_BITS-1:0] : '0;
      v.dec_overflow = dec_ok && dec_ovf;
      v.bin_valid    = bin_ok;
      v.bin_value    = bin_ok ? bin_acc[OUT_BITS-1:0] : '0;
      v.bin_overflow = bin_ok && bin_ovf;
      v.hex_valid    = hv;
      v.hex_value    = hv ? hex_acc[OUT_BITS-1:0] : '0;
      v.hex_overflow = hv && hex_ovf;
      clear_literal();
      return 1'b1;
    end
    if (dec_ok) begin
      if (c >= CH_ZERO && c <= CH_NINE)
        sat_mac(dec_acc, dec_ovf, 64'd10, 64'(c - CH_ZERO));
      else
        dec_ok = 1'b0;
    end
    if (bin_ok) begin
      if (c == CH_ZERO || c == CH_ONE)
        sat_mac(bin_acc, bin_ovf, 64'd2, 64'(c - CH_ZERO));
      else
        bin_ok = 1'b0;
    end
    if (hex_ok) begin
      case (seen)
        POS_FIRST:  hex_ok = (c == CH_ZERO);
        POS_SECOND: hex_ok = (c == CH_X);
        default: begin
          nib = -1;
          if (c >= CH_ZERO && c <= CH_NINE) nib = int'(c) - int'(CH_ZERO);
          else if (c >= CH_UP_A && c <= CH_UP_F) nib = int'(c) - int'(CH_UP_A) + 10;
          else if (c >= CH_LO_A && c <= CH_LO_F) nib = int'(c) - int'(CH_LO_A) + 10;
          if (nib < 0) hex_ok = 1'b0;
          else sat_mac(hex_acc, hex_ovf, 64'd16, 64'(nib));
        end
      endcase
    end
    if (seen != POS_DIGITS) seen = seen + 2'd1;
    return 1'b0;
  endfunction

  // Queue a string and its terminator as directed rows
  function automatic void add_literal(string s, bit typed, verdict_t want);
    stim_row_t row;
    row.typed = 1'b0;
    row.want = '0;
    for (int i = 0; i < s.len(); i++) begin
      row.ch = s[i];
      directed_rows.push_back(row);
    end
    row.ch = CH_NUL;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endfunction

  // Offer one byte, idling at random first; hold it until taken
  task automatic send_byte(input logic [CH_BITS-1:0] c, input bit typed,
                           input verdict_t want);
    verdict_t v;
    while ($urandom_range(99) < send_idle_pct) begin
      chars.valid <= 1'b0;
      @(posedge clk);
    end
    chars.valid <= 1'b1;
    chars.ch <= c;
    @(posedge clk);
    while (!chars.ready) @(posedge clk);
    if (parse_byte(c, v)) pending_verdicts.push_back(typed ? want : v);
    sent_bytes++;
  endtask

  // Build one literal: mostly well-formed, some noise, some with a stray byte
  task automatic send_random_literal();
    logic [CH_BITS-1:0] text[$];
    int len;
    int pick;
    case ($urandom_range(9))
      0, 1: begin
        len = $urandom_range(12);
        repeat (len) text.push_back(CH_ZERO + 8'($urandom_range(9)));
      end
      2, 3: begin
        len = $urandom_range(34);
        repeat (len) text.push_back(CH_ZERO + 8'($urandom_range(1)));
      end
      4, 5, 6: begin
        text.push_back(CH_ZERO);
        text.push_back(CH_X);
        len = $urandom_range(10);
        repeat (len) begin
          pick = $urandom_range(21);
          if (pick < 10) text.push_back(CH_ZERO + 8'(pick));
          else if (pick < 16) text.push_back(CH_UP_A + 8'(pick - 10));
          else text.push_back(CH_LO_A + 8'(pick - 16));
        end
      end
      7: begin
        len = $urandom_range(6);
        repeat (len) text.push_back(8'($urandom_range(1, 255)));
      end
      default: begin
        // short mixes of prefix characters
        len = $urandom_range(4);
        repeat (len) begin
          case ($urandom_range(5))
            0:       text.push_back(CH_ZERO);
            1:       text.push_back(CH_X);
            2:       text.push_back(CH_UP_X);
            3:       text.push_back(CH_ONE);
            4:       text.push_back(CH_NINE);
            default: text.push_back(CH_LO_F);
          endcase
        end
      end
    endcase
    // corrupt one byte now and then
    if (text.size() > 0 && $urandom_range(7) == 0)
      text[$urandom_range(text.size() - 1)] = 8'($urandom_range(1, 255));
    foreach (text[i]) send_byte(text[i], 1'b0, '0);
    send_byte(CH_NUL, 1'b0, '0);
  endtask

  // Drop valid and hold off until every expected word has come back
  task automatic pause_until_drained();
    chars.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  function automatic void check_field(string name, logic [OUT_BITS-1:0] want,
                                      logic [OUT_BITS-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Compare an accepted result word with the oldest expectation
  task automatic check_verdict();
    verdict_t want;
    verdict_t got;
    got = '{results.dec_valid, results.dec_value, results.dec_overflow,
            results.bin_valid, results.bin_value, results.bin_overflow,
            results.hex_valid, results.hex_value, results.hex_overflow};
    if (pending_verdicts.size() == 0) begin
      $display("%0t: result word with none expected, expected nothing, got %h",
               $time, got);
      errors++;
    end else begin
      want = pending_verdicts.pop_front();
      check_field("dec_valid", OUT_BITS'(want.dec_valid), OUT_BITS'(got.dec_valid));
      check_field("dec_value", want.dec_value, got.dec_value);
      check_field("dec_overflow", OUT_BITS'(want.dec_overflow),
                  OUT_BITS'(got.dec_overflow));
      check_field("bin_valid", OUT_BITS'(want.bin_valid), OUT_BITS'(got.bin_valid));
      check_field("bin_value", want.bin_value, got.bin_value);
      check_field("bin_overflow", OUT_BITS'(want.bin_overflow),
                  OUT_BITS'(got.bin_overflow));
      check_field("hex_valid", OUT_BITS'(want.hex_valid), OUT_BITS'(got.hex_valid));
      check_field("hex_value", want.hex_value, got.hex_value);
      check_field("hex_overflow", OUT_BITS'(want.hex_overflow),
                  OUT_BITS'(got.hex_overflow));
    end
  endtask

  // Stall the result side at random and check each word taken
  always @(posedge clk) begin
    if (rst) begin
      results.ready <= 1'b0;
    end else begin
      results.ready <= ($urandom_range(99) >= stall_pct);
      if (results.valid && results.ready) check_verdict();
    end
  end

  initial begin
    rst <= 1'b1;
    chars.valid <= 1'b0;
    chars.ch <= CH_NUL;
    clear_literal();

    // empty string: decimal and binary zero, no hex
    add_literal("", 1'b1, '{1'b1, 31'd0, 1'b0, 1'b1, 31'd0, 1'b0, 1'b0, 31'd0, 1'b0});
    // bare prefix: hex zero only
    add_literal("0x", 1'b1, '{1'b0, 31'd0, 1'b0, 1'b0, 31'd0, 1'b0, 1'b1, 31'd0, 1'b0});
    add_literal("1", 1'b1, '{1'b1, 31'd1, 1'b0, 1'b1, 31'd1, 1'b0, 1'b0, 31'd0, 1'b0});
    // top byte value: nothing valid
    add_literal("\377", 1'b1, '0);
    // hex past the maximum saturates and flags overflow
    add_literal("0xaF000000", 1'b1,
                '{1'b0, 31'd0, 1'b0, 1'b0, 31'd0, 1'b0, 1'b1, 31'h7FFF_FFFF, 1'b1});
    // uppercase X is no prefix
    add_literal("0X9", 1'b0, '0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 78; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 78; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      if (phase == 0)
        foreach (directed_rows[i])
          send_byte(directed_rows[i].ch, directed_rows[i].typed, directed_rows[i].want);
      sent_bytes = 0;
      while (sent_bytes < PHASE_BYTES) send_random_literal();
      pause_until_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
